>>> rtl/core/assert_macros.svh
// assertion macros used by the top level of the engine
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on the block clock, off during reset
`define TLPT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("page table engine check failed");

// next-cycle implication, sampled on the block clock, off during reset
`define TLPT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("page table engine check failed");

`endif

>>> rtl/core/tlpt_pkg.sv
// types, constants and helpers of the two-level page table engine
package tlpt_pkg;

    // fixed geometry
    localparam int DIR_ENTRIES   = 1024;
    localparam int TABLE_ENTRIES = 1024;
    localparam int PAGE_BYTES    = 4096;
    localparam int DIR_W         = $clog2(DIR_ENTRIES);
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int PAGE_SHIFT    = $clog2(PAGE_BYTES);
    localparam int FRAME_W       = 32 - PAGE_SHIFT;

    // entry word layout
    localparam logic [31:0] PAGE_MASK   = 32'hFFFF_F000;
    localparam logic [11:0] ATTR_MASK   = 12'h0FFF;
    localparam logic [11:0] ENTRY_VALID = 12'h001;
    localparam logic [11:0] ENTRY_WRITE = 12'h002;

    // command codes
    localparam logic CMD_MAP    = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    // status codes
    localparam logic ST_DONE     = 1'b0;
    localparam logic ST_NO_TABLE = 1'b1;

    // configuration register indexes
    localparam logic CFG_POOL_BASE   = 1'b0;
    localparam logic CFG_TABLES_AVAIL = 1'b1;

    // request as seen on the ports
    typedef struct packed {
        logic        command;
        logic [31:0] virt_addr;
        logic [31:0] phys_page_addr;
    } t_req;

    // result as seen on the ports
    typedef struct packed {
        logic        status;
        logic [31:0] entry_word;
        logic [11:0] attributes;
        logic        page_valid;
        logic [31:0] frame_addr;
    } t_rsp;

    // classified request held in the queue
    typedef struct packed {
        logic               is_map;
        logic [DIR_W-1:0]   dir_idx;
        logic [IDX_W-1:0]   tbl_idx;
        logic [FRAME_W-1:0] frame;
    } t_op;

    // queue head handed to the back end
    typedef struct packed {
        logic valid;
        t_op  op;
    } t_qhead;

    // build a result from a status and an entry word
    function automatic t_rsp make_rsp(logic status, logic [31:0] entry);
        t_rsp r;
        r.status     = status;
        r.entry_word = entry;
        r.attributes = entry[11:0] & ATTR_MASK;
        r.page_valid = entry[0];
        r.frame_addr = entry[0] ? (entry & PAGE_MASK) : 32'hFFFF_FFFF;
        return r;
    endfunction

endpackage

>>> rtl/core/tlpt_front.sv
// front end: classifies accepted requests and queues them for the walker
module tlpt_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  tlpt_pkg::t_req  i_req,
    input  logic            i_pop,
    output tlpt_pkg::t_qhead o_head
);
    import tlpt_pkg::*;

    t_op        n_op;
    t_op        r_q [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    // split the virtual address into directory and table index, keep the frame
    always_comb begin
        n_op.is_map  = (i_req.command == CMD_MAP);
        n_op.dir_idx = i_req.virt_addr[31 -: DIR_W];
        n_op.tbl_idx = i_req.virt_addr[PAGE_SHIFT +: IDX_W];
        n_op.frame   = i_req.phys_page_addr[31:PAGE_SHIFT];
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr_ptr] <= n_op;
        end
    end

    // queue pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_head.valid = (r_count != 2'd0);
    assign o_head.op    = r_q[r_rd_ptr];

endmodule

>>> rtl/core/tlpt_back.sv
// back end: directory and table memories, allocation and the two-level walk
module tlpt_back #(
    parameter int TABLE_POOL = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tlpt_pkg::t_qhead i_head,
    input  logic [4:0]       i_tables_avail,
    output logic             o_pop,
    output logic             o_busy,
    output logic             o_clearing,
    output logic             o_done,
    output tlpt_pkg::t_rsp   o_rsp
);
    import tlpt_pkg::*;

    localparam int TW    = (TABLE_POOL > 1) ? $clog2(TABLE_POOL) : 1;
    localparam int UW    = $clog2(TABLE_POOL + 1);
    localparam int SLOTS = TABLE_POOL * TABLE_ENTRIES;
    localparam int AW    = TW + IDX_W;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_DIR   = 4'b0100,
        S_TBL   = 4'b1000
    } t_state;

    t_state          r_state, n_state;
    logic [AW-1:0]   r_clr_addr, n_clr_addr;
    logic [UW-1:0]   r_used, n_used;
    t_op             r_op;
    logic [TW:0]     r_dir_q;
    logic [31:0]     r_tbl_q;
    logic            r_done, n_done;
    t_rsp            r_rsp, n_rsp;

    logic [TW:0]     dir_mem [DIR_ENTRIES];
    logic [31:0]     tbl_mem [SLOTS];

    logic            dir_re, dir_we;
    logic [DIR_W-1:0] dir_waddr;
    logic [TW:0]     dir_wdata;
    logic            tbl_re, tbl_we;
    logic [AW-1:0]   tbl_raddr, tbl_waddr;
    logic [31:0]     tbl_wdata;

    logic            dir_hit;
    logic [TW-1:0]   dir_tbl;
    logic            exhausted;
    logic [31:0]     map_entry;

    assign dir_hit   = r_dir_q[TW];
    assign dir_tbl   = r_dir_q[TW-1:0];
    assign exhausted = (32'(r_used) >= 32'(TABLE_POOL)) ||
                       (32'(r_used) >= 32'(i_tables_avail));
    assign map_entry = {r_op.frame, ENTRY_VALID | ENTRY_WRITE};

    // walk sequencer
    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_used     = r_used;
        n_done     = 1'b0;
        n_rsp      = r_rsp;
        o_pop      = 1'b0;
        dir_re     = 1'b0;
        dir_we     = 1'b0;
        dir_waddr  = r_op.dir_idx;
        dir_wdata  = '0;
        tbl_re     = 1'b0;
        tbl_we     = 1'b0;
        tbl_raddr  = {dir_tbl, r_op.tbl_idx};
        tbl_waddr  = {dir_tbl, r_op.tbl_idx};
        tbl_wdata  = map_entry;
        case (r_state)
            S_CLEAR: begin
                // sweep both stores after reset
                tbl_we    = 1'b1;
                tbl_waddr = r_clr_addr;
                tbl_wdata = '0;
                dir_we    = (r_clr_addr[AW-1:IDX_W] == '0);
                dir_waddr = r_clr_addr[DIR_W-1:0];
                n_clr_addr = r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(SLOTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_head.valid) begin
                    o_pop   = 1'b1;
                    dir_re  = 1'b1;
                    n_state = S_DIR;
                end
            end
            S_DIR: begin
                n_state = S_IDLE;
                if (r_op.is_map) begin
                    if (!dir_hit && exhausted) begin
                        n_done = 1'b1;
                        n_rsp  = make_rsp(ST_NO_TABLE, 32'd0);
                    end else begin
                        if (!dir_hit) begin
                            // allocate the next table from the pool
                            dir_we    = 1'b1;
                            dir_wdata = {1'b1, TW'(r_used)};
                            tbl_waddr = {TW'(r_used), r_op.tbl_idx};
                            n_used    = r_used + UW'(1);
                        end
                        tbl_we = 1'b1;
                        n_done = 1'b1;
                        n_rsp  = make_rsp(ST_DONE, map_entry);
                    end
                end else if (!dir_hit) begin
                    n_done = 1'b1;
                    n_rsp  = make_rsp(ST_DONE, 32'd0);
                end else begin
                    tbl_re  = 1'b1;
                    n_state = S_TBL;
                end
            end
            S_TBL: begin
                n_done  = 1'b1;
                n_rsp   = make_rsp(ST_DONE, r_tbl_q);
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // directory memory
    always_ff @(posedge i_clk) begin
        if (dir_we) begin
            dir_mem[dir_waddr] <= dir_wdata;
        end
        if (dir_re) begin
            r_dir_q <= dir_mem[i_head.op.dir_idx];
        end
    end

    // page table memory
    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            tbl_mem[tbl_waddr] <= tbl_wdata;
        end
        if (tbl_re) begin
            r_tbl_q <= tbl_mem[tbl_raddr];
        end
    end

    // request being walked and result payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_op <= i_head.op;
        end
        r_rsp <= n_rsp;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_used     <= '0;
            r_done     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_used     <= n_used;
            r_done     <= n_done;
        end
    end

    assign o_busy     = (r_state != S_IDLE);
    assign o_clearing = (r_state == S_CLEAR);
    assign o_done     = r_done;
    assign o_rsp      = r_rsp;

endmodule

>>> rtl/core/two_level_page_table_engine.sv
// top level of the two-level page table engine
//
// A request (map or lookup) is taken at a clock edge where start is high and
// busy is low. A map rounds both addresses to a 4 KiB page, allocates the
// next page table from the pool when the directory slot is empty (status 1
// when the pool is used up) and writes frame|write|valid. A lookup walks the
// directory and the table and returns the raw entry, its attributes, valid
// bit and frame address.
// Each request gives exactly one result, shown on o_rsp for one cycle with
// o_done high; the receiver cannot stall it.
// Timing: o_done follows the directory read for a map or a lookup that stops
// at the directory, and the directory and table reads for a lookup that
// reads a table. One request is in flight at a time and busy drops while
// o_done is high, so a new request can be taken while the last result is
// shown; the directory read and the dependent table access set the spacing.
// Configuration: register 0 is the pool base (it is not kept and affects no
// result), register 1 the number of tables that may be allocated. Write
// only while busy is low.
// After reset the block sweeps its directory and table memories, one table
// word per cycle over all TABLE_POOL * 1024 words; busy stays high until then.
`include "assert_macros.svh"

module two_level_page_table_engine #(
    parameter int TABLE_POOL = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  tlpt_pkg::t_req i_req,
    output logic           o_done,
    output tlpt_pkg::t_rsp o_rsp,
    input  logic           i_cfg_we,
    input  logic [0:0]     i_cfg_idx,
    input  logic [31:0]    i_cfg_wdata
);
    import tlpt_pkg::*;

    logic   accept;
    logic   pop;
    logic   back_busy;
    logic   clearing;
    t_qhead head;
    logic [4:0] r_tables_avail;

    assign busy   = back_busy || head.valid;
    assign accept = start && !busy;

    // configuration; the pool base has no effect on results and is not kept
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tables_avail <= 5'd16;
        end else if (i_cfg_we && (i_cfg_idx == CFG_TABLES_AVAIL)) begin
            r_tables_avail <= i_cfg_wdata[4:0];
        end
    end

    // request classification and queue
    tlpt_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_req   (i_req),
        .i_pop   (pop),
        .o_head  (head)
    );

    // table walk and allocation
    tlpt_back #(
        .TABLE_POOL (TABLE_POOL)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (head),
        .i_tables_avail (r_tables_avail),
        .o_pop          (pop),
        .o_busy         (back_busy),
        .o_clearing     (clearing),
        .o_done         (o_done),
        .o_rsp          (o_rsp)
    );

    // checks
    `TLPT_ASSERT_NEXT(a_accept_then_busy, accept, busy)
    `TLPT_ASSERT_NOW(a_no_result_while_clearing, clearing, !o_done)
    `TLPT_ASSERT_NOW(a_fail_is_empty, o_done && (o_rsp.status == ST_NO_TABLE), (o_rsp.entry_word == 32'd0) && (o_rsp.frame_addr == 32'hFFFF_FFFF))
    `TLPT_ASSERT_NOW(a_frame_matches_entry, o_done && o_rsp.page_valid, o_rsp.frame_addr == (o_rsp.entry_word & PAGE_MASK))

endmodule

>>> dv/two_level_page_table_engine_tb.sv
// self-checking testbench for the two-level page table engine
`timescale 1ns / 1ps

module two_level_page_table_engine_tb;
    import tlpt_pkg::*;

    localparam int POOL_TABLES   = 16;
    localparam int HOT_DIRS      = 24;
    localparam int HOT_SLOTS     = 8;
    localparam int PHASES        = 8;
    localparam int PHASE_REQS    = 250;
    localparam int DRAIN_CYCLES  = 8;
    localparam int CYCLE_LIMIT   = 600000;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        start       = 1'b0;
    logic        busy;
    t_req        i_req       = '0;
    logic        o_done;
    t_rsp        o_rsp;
    logic        i_cfg_we    = 1'b0;
    logic [0:0]  i_cfg_idx   = '0;
    logic [31:0] i_cfg_wdata = '0;

    two_level_page_table_engine #(
        .TABLE_POOL(POOL_TABLES)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_req      (i_req),
        .o_done     (o_done),
        .o_rsp      (o_rsp),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata)
    );

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // mirror of the page tables and the allocation state
    bit          dir_valid   [DIR_ENTRIES];
    logic [4:0]  dir_table   [DIR_ENTRIES];
    logic [31:0] table_words [POOL_TABLES*TABLE_ENTRIES];
    int unsigned tables_alloc;
    logic [31:0] cfg_pool_base;
    logic [4:0]  cfg_tables_avail;

    t_req        pending_reqs  [$];
    t_rsp        expected_rsps [$];
    logic        req_taken = 1'b0;
    int          gap_left  = 0;
    bit          quiet     = 1'b0;
    int          errors    = 0;
    int unsigned cycles    = 0;
    int unsigned n_maps, n_lookups, n_refused, n_hits, n_limits;

    logic [DIR_W-1:0] hot_dirs  [HOT_DIRS];
    logic [IDX_W-1:0] hot_slots [HOT_SLOTS];

    // result fields derived from a status and an entry word
    function automatic t_rsp build_result(logic status, logic [31:0] entry);
        t_rsp r;
        r.status     = status;
        r.entry_word = entry;
        r.attributes = entry[11:0];
        r.page_valid = |(entry[11:0] & ENTRY_VALID);
        r.frame_addr = r.page_valid ? (entry & PAGE_MASK) : 32'hFFFF_FFFF;
        return r;
    endfunction

    // two-level walk: allocate on map when needed, then write or read the entry
    function automatic t_rsp apply_request(t_req req);
        logic [31:0]      va;
        logic [31:0]      pa;
        logic [31:0]      entry;
        logic [DIR_W-1:0] d;
        logic [IDX_W-1:0] ti;
        int unsigned      limit;
        va = req.virt_addr & PAGE_MASK;
        pa = req.phys_page_addr & PAGE_MASK;
        d  = va[31:22];
        ti = va[21:12];
        if (req.command == CMD_MAP) begin
            if (!dir_valid[d]) begin
                limit = (cfg_tables_avail > POOL_TABLES) ? POOL_TABLES : cfg_tables_avail;
                if (tables_alloc >= limit)
                    return build_result(ST_NO_TABLE, 32'h0);
                dir_table[d] = 5'(tables_alloc);
                dir_valid[d] = 1'b1;
                tables_alloc++;
            end
            entry = pa | {20'h0, ENTRY_WRITE} | {20'h0, ENTRY_VALID};
            table_words[int'(dir_table[d]) * TABLE_ENTRIES + int'(ti)] = entry;
            return build_result(ST_DONE, entry);
        end
        if (!dir_valid[d])
            return build_result(ST_DONE, 32'h0);
        return build_result(ST_DONE, table_words[int'(dir_table[d]) * TABLE_ENTRIES + int'(ti)]);
    endfunction

    task automatic check_field(string fname, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, want, got);
        end
    endtask

    // random gap before the next request: mostly short, a few long, quiet stretches
    function automatic int pick_gap();
        int r;
        if ($urandom_range(0, 63) == 0)
            quiet = !quiet;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // request driver, changes inputs on the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || req_taken) begin
            if (req_taken)
                gap_left = pick_gap();
            if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                i_req <= pending_reqs.pop_front();
                start <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor: check results, track config writes, predict accepted requests
    always @(posedge i_clk) begin : rsp_monitor
        t_rsp want;
        if (!i_rst_n) begin
            for (int i = 0; i < DIR_ENTRIES; i++) begin
                dir_valid[i] = 1'b0;
                dir_table[i] = '0;
            end
            for (int i = 0; i < POOL_TABLES*TABLE_ENTRIES; i++)
                table_words[i] = '0;
            tables_alloc     = 0;
            cfg_pool_base    = 32'h0010_0000;
            cfg_tables_avail = 5'd16;
            req_taken <= 1'b0;
        end else begin
            if (o_done !== 1'b0) begin
                if (expected_rsps.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, expected none, actual %h", $time, o_rsp);
                end else begin
                    want = expected_rsps.pop_front();
                    check_field("status", 32'(want.status), 32'(o_rsp.status));
                    check_field("entry_word", want.entry_word, o_rsp.entry_word);
                    check_field("attributes", 32'(want.attributes), 32'(o_rsp.attributes));
                    check_field("page_valid", 32'(want.page_valid), 32'(o_rsp.page_valid));
                    check_field("frame_addr", want.frame_addr, o_rsp.frame_addr);
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_POOL_BASE:    cfg_pool_base = i_cfg_wdata;
                    CFG_TABLES_AVAIL: cfg_tables_avail = i_cfg_wdata[4:0];
                    default:          ;
                endcase
            end
            if (start && !busy) begin
                want = apply_request(i_req);
                expected_rsps.push_back(want);
                if (i_req.command == CMD_MAP) begin
                    n_maps++;
                    if (want.status == ST_NO_TABLE)
                        n_refused++;
                end else begin
                    n_lookups++;
                    if (want.page_valid)
                        n_hits++;
                end
            end
            req_taken <= start && !busy;
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("run limit of %0d cycles reached", CYCLE_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    task automatic add_req(logic cmd, logic [31:0] va, logic [31:0] pa);
        t_req r;
        r.command        = cmd;
        r.virt_addr      = va;
        r.phys_page_addr = pa;
        pending_reqs.push_back(r);
    endtask

    // wait until every request is answered and the block is idle again
    task automatic wait_idle();
        while (pending_reqs.size() != 0 || start || expected_rsps.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        while (busy !== 1'b0)
            @(negedge i_clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [31:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == CFG_TABLES_AVAIL)
            n_limits++;
        @(posedge i_clk);
    endtask

    // random request: mostly a small working set of directories and slots
    function automatic t_req rand_request();
        t_req             r;
        logic [DIR_W-1:0] d;
        logic [IDX_W-1:0] t;
        logic [11:0]      offs;
        r.command = $urandom_range(0, 1) ? CMD_LOOKUP : CMD_MAP;
        d    = hot_dirs[$urandom_range(0, HOT_DIRS-1)];
        t    = hot_slots[$urandom_range(0, HOT_SLOTS-1)];
        offs = 12'($urandom);
        if ($urandom_range(0, 4) == 0)
            t = IDX_W'($urandom);
        r.virt_addr = {d, t, offs};
        if ($urandom_range(0, 9) == 0)
            r.virt_addr = $urandom;
        r.phys_page_addr = $urandom;
        return r;
    endfunction

    // stimulus
    initial begin : stimulus
        logic [4:0] avail;
        hot_dirs[0]  = '0;
        hot_dirs[1]  = '1;
        for (int i = 2; i < HOT_DIRS; i++)
            hot_dirs[i] = DIR_W'($urandom);
        hot_slots[0] = '0;
        hot_slots[1] = '1;
        for (int i = 2; i < HOT_SLOTS; i++)
            hot_slots[i] = IDX_W'($urandom);

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        wait_idle();

        // no tables allowed: map refused, lookup sees an empty directory
        write_reg(CFG_TABLES_AVAIL, 32'd0);
        write_reg(CFG_POOL_BASE, 32'h0000_0000);
        add_req(CMD_MAP, 32'h0000_0000, 32'h1234_5678);
        add_req(CMD_LOOKUP, 32'h0000_0000, 32'h0);
        wait_idle();

        // two tables: rounding, address extremes, unwritten slot, remap, pool exhausted
        write_reg(CFG_TABLES_AVAIL, 32'd2);
        write_reg(CFG_POOL_BASE, 32'hFFFF_F000);
        add_req(CMD_MAP, 32'h0000_0FFF, 32'hFFFF_FFFF);
        add_req(CMD_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);
        add_req(CMD_LOOKUP, 32'h0000_1000, 32'h0);
        add_req(CMD_MAP, 32'hFFFF_FFFF, 32'h0000_0000);
        add_req(CMD_LOOKUP, 32'hFFFF_F123, 32'h0);
        add_req(CMD_MAP, 32'h0040_0000, 32'hABCD_E000);
        add_req(CMD_MAP, 32'h0000_0000, 32'h5A5A_5FFF);
        add_req(CMD_LOOKUP, 32'h0000_0ABC, 32'h0);
        add_req(CMD_MAP, 32'h003F_F000, 32'h8000_0000);
        add_req(CMD_LOOKUP, 32'h003F_FFFF, 32'h0);
        add_req(CMD_LOOKUP, 32'hFFC0_0000, 32'h0);
        wait_idle();

        // limit lowered below the tables already in use
        write_reg(CFG_TABLES_AVAIL, 32'd1);
        add_req(CMD_MAP, 32'h0080_0000, 32'h0000_1000);
        add_req(CMD_MAP, 32'hFFC0_1000, 32'h0000_1000);
        add_req(CMD_LOOKUP, 32'hFFC0_1000, 32'h0);
        add_req(CMD_LOOKUP, 32'h0080_0000, 32'h0);
        wait_idle();

        // random phases, each under its own pool limit
        for (int p = 0; p < PHASES; p++) begin
            if (p == 5)
                avail = 5'd0;
            else if (p % 3 == 1 || p == PHASES-1)
                avail = 5'd16;
            else
                avail = 5'($urandom_range(1, 15));
            write_reg(CFG_TABLES_AVAIL, {27'h0, avail});
            write_reg(CFG_POOL_BASE, $urandom);
            for (int i = 0; i < PHASE_REQS; i++)
                pending_reqs.push_back(rand_request());
            wait_idle();
        end

        $display("checked %0d maps (%0d refused, no table free) and %0d lookups (%0d valid pages)",
                 n_maps, n_refused, n_lookups, n_hits);
        $display("pool limit set %0d times, %0d of %0d tables allocated",
                 n_limits, tables_alloc, POOL_TABLES);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/tlpt_pkg.sv
rtl/core/tlpt_front.sv
rtl/core/tlpt_back.sv
rtl/core/two_level_page_table_engine.sv
dv/two_level_page_table_engine_tb.sv
